@@ design/ttc_pkg.sv @@
// ----------------------------------------------------------------------------
// ttc_pkg
// shared types, constants and helpers for the toroidal tile cache
// ----------------------------------------------------------------------------
`default_nettype none

package ttc_pkg;

  localparam int WINDOW_LOG2 = 3;
  localparam int TILE_SHIFT  = 4;
  localparam int WIN         = 1 << WINDOW_LOG2;
  localparam int HALF        = WIN / 2;
  localparam int SLOTS       = WIN * WIN;
  localparam int SLOT_W      = 2 * WINDOW_LOG2;
  localparam int TILE_W      = 17;
  localparam int WORLD_W     = 21;
  localparam int DIST_W      = 6;
  localparam int MAXREQ_W    = 7;
  localparam int CNT_W       = SLOT_W + 1;
  localparam int RING_W      = WINDOW_LOG2;

  localparam logic [MAXREQ_W-1:0] MAXREQ_RESET = MAXREQ_W'(64);

  typedef enum logic [1:0] {
    MODE_SET     = 2'd0,
    MODE_INSTALL = 2'd1,
    MODE_LOOKUP  = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_REQUEST = 2'd0,
    KIND_INSTALL = 2'd1,
    KIND_LOOKUP  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INSTALL_RD,
    ST_INSTALL_WR,
    ST_LOOKUP_RD,
    ST_LOOKUP_CMP,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_EMIT_RD,
    ST_EMIT,
    ST_EMPTY,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [TILE_W-1:0] x;
    logic [TILE_W-1:0] y;
  } tag_t;

  function automatic logic [TILE_W-1:0] tile_of_world(input logic [WORLD_W-1:0] w);
    logic signed [WORLD_W-1:0] s;
    logic signed [WORLD_W-1:0] r;
    s = w;
    r = s >>> TILE_SHIFT;
    return r[TILE_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(input logic [TILE_W-1:0] tx,
                                                input logic [TILE_W-1:0] ty);
    return {ty[WINDOW_LOG2-1:0], tx[WINDOW_LOG2-1:0]};
  endfunction

endpackage

`default_nettype wire

@@ design/ttc_tag_ram.sv @@
// ----------------------------------------------------------------------------
// ttc_tag_ram
// tag store, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module ttc_tag_ram (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [ttc_pkg::SLOT_W-1:0] waddr,
  input  ttc_pkg::tag_t              wdata,
  input  wire logic [ttc_pkg::SLOT_W-1:0] raddr,
  output ttc_pkg::tag_t              rdata
);
  import ttc_pkg::*;

  tag_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/ttc_req_ram.sv @@
// ----------------------------------------------------------------------------
// ttc_req_ram
// collected miss list, written in scan order, read back by distance
// ----------------------------------------------------------------------------
`default_nettype none

module ttc_req_ram (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [ttc_pkg::SLOT_W-1:0] waddr,
  input  wire logic [ttc_pkg::SLOT_W+ttc_pkg::DIST_W-1:0] wdata,
  input  wire logic [ttc_pkg::SLOT_W-1:0] raddr,
  output logic [ttc_pkg::SLOT_W+ttc_pkg::DIST_W-1:0] rdata
);
  import ttc_pkg::*;

  logic [SLOT_W+DIST_W-1:0] mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/toroidal_tile_cache_with_miss_requests.sv @@
// ----------------------------------------------------------------------------
// toroidal_tile_cache_with_miss_requests
// direct-mapped 8x8 toroidal tile tag cache with ordered miss requests
// ----------------------------------------------------------------------------
// After reset a clearing pass over all 64 slots initialises the tag memory; no
// item is taken meanwhile. Install and lookup each read the tag memory, then
// write or compare, then present the result. A position update steps through all 64
// window positions once per ring (eight rings). It reads the tag of each
// position on the current ring through the single tag memory port and stores
// misses in a request memory. It then sweeps that memory once per distance
// value in ascending order, emitting matches and stopping after the last
// request.
`default_nettype none

module toroidal_tile_cache_with_miss_requests (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [0:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  mode,
  input  wire logic [20:0] world_x,
  input  wire logic [20:0] world_y,
  input  wire logic [16:0] new_tile_x,
  input  wire logic [16:0] new_tile_y,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       result_kind,
  output logic             request_valid,
  output logic [16:0]      req_tile_x,
  output logic [16:0]      req_tile_y,
  output logic [5:0]       distance_sq,
  output logic             hit,
  output logic [5:0]       slot_index,
  output logic             last
);
  import ttc_pkg::*;

  // distinct squared distances in the window, ascending
  localparam int NDALL = 15;
  localparam logic [DIST_W-1:0] DALL [NDALL] = '{
    6'd0, 6'd1, 6'd2, 6'd4, 6'd5, 6'd8, 6'd9, 6'd10, 6'd13,
    6'd16, 6'd17, 6'd18, 6'd20, 6'd25, 6'd32
  };

  state_t state, state_next;

  logic [MAXREQ_W-1:0] max_requests;
  logic [TILE_W-1:0]   viewer_x, viewer_y;
  logic [TILE_W-1:0]   op_x, op_y;

  // scan position: ring, row, column
  logic [RING_W-1:0]   ring;
  logic [WINDOW_LOG2-1:0] row, col;
  logic [CNT_W-1:0]    nmiss;
  logic [SLOT_W-1:0]   clr_addr;

  // pending compare from previous scan read
  logic                pend;
  logic [TILE_W-1:0]   pend_x, pend_y;
  logic [DIST_W-1:0]   pend_d;
  logic [WINDOW_LOG2-1:0] pend_col, pend_row;

  // emit sweep
  logic [3:0]          dsel;
  logic [CNT_W-1:0]    eptr;
  logic [CNT_W-1:0]    nsent;

  // output register
  logic [1:0]          o_kind;
  logic                o_rv, o_hit, o_last;
  logic [TILE_W-1:0]   o_x, o_y;
  logic [DIST_W-1:0]   o_d;
  logic [SLOT_W-1:0]   o_slot;

  // memories
  logic                tag_we;
  logic [SLOT_W-1:0]   tag_waddr, tag_raddr;
  tag_t                tag_wdata, tag_rdata;
  logic                req_we;
  logic [SLOT_W-1:0]   req_raddr;
  logic [SLOT_W+DIST_W-1:0] req_wdata, req_rdata;

  ttc_tag_ram u_tag (
    .clk(clk), .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
    .raddr(tag_raddr), .rdata(tag_rdata)
  );

  ttc_req_ram u_req (
    .clk(clk), .we(req_we), .waddr(nmiss[SLOT_W-1:0]), .wdata(req_wdata),
    .raddr(req_raddr), .rdata(req_rdata)
  );

  assign pready = 1'b1;
  assign prdata = {25'd0, max_requests};

  // scan offsets for the current position
  logic signed [WINDOW_LOG2:0] dx, dy;
  logic [WINDOW_LOG2:0] adx, ady;
  logic [WINDOW_LOG2+1:0] man;
  logic [TILE_W-1:0] rx, ry;
  logic [DIST_W-1:0] dsq;
  logic scan_end;

  always_comb begin
    dx  = $signed({1'b0, col}) - (WINDOW_LOG2+1)'(HALF);
    dy  = $signed({1'b0, row}) - (WINDOW_LOG2+1)'(HALF);
    adx = dx[WINDOW_LOG2] ? -dx : dx;
    ady = dy[WINDOW_LOG2] ? -dy : dy;
    man = {1'b0, adx} + {1'b0, ady};
    rx  = viewer_x + {{(TILE_W-WINDOW_LOG2-1){dx[WINDOW_LOG2]}}, dx};
    ry  = viewer_y + {{(TILE_W-WINDOW_LOG2-1){dy[WINDOW_LOG2]}}, dy};
    dsq = DIST_W'(adx * adx) + DIST_W'(ady * ady);
    scan_end = (ring == RING_W'(WIN-1)) && (row == '1) && (col == '1);
  end

  logic visit;
  assign visit = (state == ST_SCAN) && (man == (WINDOW_LOG2+2)'(ring));

  logic pend_miss;
  assign pend_miss = pend && ((tag_rdata.x != pend_x) || (tag_rdata.y != pend_y))
                     && ({1'b0, nmiss} < {1'b0, max_requests})
                     && (nmiss < CNT_W'(SLOTS));

  logic in_acc, out_acc, out_free;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE) || out_valid;

  // wrap differences for install
  logic [TILE_W-1:0] ddx, ddy;
  logic in_win;
  always_comb begin
    ddx = op_x - viewer_x;
    ddy = op_y - viewer_y;
    in_win = ((ddx[TILE_W-1] && (&ddx[TILE_W-2:WINDOW_LOG2-1])) ||
              (!ddx[TILE_W-1] && ~(|ddx[TILE_W-2:WINDOW_LOG2-1]))) &&
             ((ddy[TILE_W-1] && (&ddy[TILE_W-2:WINDOW_LOG2-1])) ||
              (!ddy[TILE_W-1] && ~(|ddy[TILE_W-2:WINDOW_LOG2-1])));
  end

  // request memory entry: slot and distance; tile is rebuilt from viewer
  logic [DIST_W-1:0] e_d;
  logic [SLOT_W-1:0] e_slot;
  logic e_match, e_lastent, e_final, sweep_done;
  logic [TILE_W-1:0] e_x, e_y;
  logic [WINDOW_LOG2:0] e_offx, e_offy;
  always_comb begin
    e_slot = req_rdata[SLOT_W+DIST_W-1:DIST_W];
    e_d    = req_rdata[DIST_W-1:0];
    e_match = (e_d == DALL[dsel]);
    e_lastent = (eptr == nmiss - CNT_W'(1));
    e_final = e_match && (nsent + CNT_W'(1) == nmiss);
    // offset in window so that tile low bits equal slot column/row
    e_offx = {1'b0, e_slot[WINDOW_LOG2-1:0] - viewer_x[WINDOW_LOG2-1:0]
              + WINDOW_LOG2'(HALF)};
    e_offy = {1'b0, e_slot[SLOT_W-1:WINDOW_LOG2] - viewer_y[WINDOW_LOG2-1:0]
              + WINDOW_LOG2'(HALF)};
    e_x = viewer_x + TILE_W'(e_offx) - TILE_W'(HALF);
    e_y = viewer_y + TILE_W'(e_offy) - TILE_W'(HALF);
    sweep_done = e_lastent && (dsel == 4'(NDALL-1));
  end

  logic out_load;
  assign out_load = out_free && ((state == ST_EMPTY) || (state == ST_OUT) ||
                                 ((state == ST_EMIT) && e_match));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:      if (clr_addr == '1) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          unique case (mode_t'(mode))
            MODE_SET:     state_next = ST_SCAN;
            MODE_INSTALL: state_next = ST_INSTALL_RD;
            MODE_LOOKUP:  state_next = ST_LOOKUP_RD;
            MODE_NONE:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_INSTALL_RD: state_next = ST_INSTALL_WR;
      ST_INSTALL_WR: state_next = ST_OUT;
      ST_LOOKUP_RD:  state_next = ST_LOOKUP_CMP;
      ST_LOOKUP_CMP: state_next = ST_OUT;
      ST_SCAN:       if (scan_end) state_next = ST_SCAN_LAST;
      ST_SCAN_LAST:  state_next = (nmiss == '0 && !pend_miss) ? ST_EMPTY : ST_EMIT_RD;
      ST_EMIT_RD:    state_next = ST_EMIT;
      ST_EMIT: begin
        if (!e_match || out_free) begin
          state_next = (sweep_done || e_final) ? ST_IDLE : ST_EMIT_RD;
        end
      end
      ST_EMPTY:      if (out_free) state_next = ST_IDLE;
      ST_OUT:        if (out_free) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    tag_we    = 1'b0;
    tag_waddr = slot_of(op_x, op_y);
    tag_wdata = '{x: op_x, y: op_y};
    tag_raddr = slot_of(rx, ry);
    req_we    = pend_miss;
    req_wdata = {pend_row, pend_col, pend_d};
    req_raddr = eptr[SLOT_W-1:0];
    unique case (state)
      ST_CLEAR: begin
        tag_we    = 1'b1;
        tag_waddr = clr_addr;
        tag_wdata = '{x: TILE_W'(clr_addr[WINDOW_LOG2-1:0]) + TILE_W'(1), y: '0};
      end
      ST_INSTALL_RD, ST_LOOKUP_RD: tag_raddr = slot_of(op_x, op_y);
      ST_INSTALL_WR: tag_we = in_win;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      max_requests <= MAXREQ_RESET;
      viewer_x     <= '0;
      viewer_y     <= '0;
      out_valid    <= 1'b0;
      pend         <= 1'b0;
      nmiss        <= '0;
      ring         <= '0;
      row          <= '0;
      col          <= '0;
      dsel         <= '0;
      eptr         <= '0;
      nsent        <= '0;
    end else begin
      state <= state_next;
      if (psel && penable && pwrite && pready && paddr == 1'b0) begin
        max_requests <= pwdata[MAXREQ_W-1:0];
      end
      if (out_load) out_valid <= 1'b1;
      else if (out_acc) out_valid <= 1'b0;
      if (req_we) nmiss <= nmiss + CNT_W'(1);
      pend <= visit;
      if (visit) begin
        pend_x <= rx; pend_y <= ry; pend_d <= dsq;
        pend_col <= rx[WINDOW_LOG2-1:0];
        pend_row <= ry[WINDOW_LOG2-1:0];
      end
      unique case (state)
        ST_CLEAR: clr_addr <= clr_addr + SLOT_W'(1);
        ST_IDLE: begin
          if (in_acc) begin
            if (mode_t'(mode) == MODE_LOOKUP) begin
              op_x <= tile_of_world(world_x);
              op_y <= tile_of_world(world_y);
            end else begin
              op_x <= new_tile_x;
              op_y <= new_tile_y;
            end
            if (mode_t'(mode) == MODE_SET) begin
              viewer_x <= tile_of_world(world_x);
              viewer_y <= tile_of_world(world_y);
              nmiss <= '0; ring <= '0; row <= '0; col <= '0;
              dsel <= '0; eptr <= '0; nsent <= '0;
            end
          end
        end
        ST_INSTALL_WR: begin
          o_kind <= KIND_INSTALL; o_hit <= in_win;
          o_slot <= slot_of(op_x, op_y);
          o_rv <= 1'b0; o_x <= '0; o_y <= '0; o_d <= '0; o_last <= 1'b1;
        end
        ST_LOOKUP_CMP: begin
          o_kind <= KIND_LOOKUP;
          o_hit  <= (tag_rdata.x == op_x) && (tag_rdata.y == op_y);
          o_slot <= slot_of(op_x, op_y);
          o_rv <= 1'b0; o_x <= '0; o_y <= '0; o_d <= '0; o_last <= 1'b1;
        end
        ST_SCAN: begin
          col <= col + WINDOW_LOG2'(1);
          if (col == '1) begin
            row <= row + WINDOW_LOG2'(1);
            if (row == '1) ring <= ring + RING_W'(1);
          end
        end
        ST_EMPTY: begin
          if (out_free) begin
            o_kind <= KIND_REQUEST; o_rv <= 1'b0; o_x <= '0; o_y <= '0;
            o_d <= '0; o_hit <= 1'b0; o_slot <= '0; o_last <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (!e_match || out_free) begin
            if (e_match) begin
              o_kind <= KIND_REQUEST; o_rv <= 1'b1;
              o_x <= e_x; o_y <= e_y; o_d <= e_d; o_hit <= 1'b0;
              o_slot <= e_slot;
              o_last <= e_final;
              nsent <= nsent + CNT_W'(1);
            end
            if (e_lastent) begin
              eptr <= '0;
              dsel <= dsel + 4'd1;
            end else begin
              eptr <= eptr + CNT_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign result_kind   = o_kind;
  assign request_valid = o_rv;
  assign req_tile_x    = o_x;
  assign req_tile_y    = o_y;
  assign distance_sq   = o_d;
  assign hit           = o_hit;
  assign slot_index    = o_slot;
  assign last          = o_last;

endmodule

`default_nettype wire

@@ sim/toroidal_tile_cache_with_miss_requests_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toroidal_tile_cache_with_miss_requests_test
// drives position updates, tile installs and lookups through the cache and
// checks every result transfer against an in-bench model of the tag store
// ----------------------------------------------------------------------------

module toroidal_tile_cache_with_miss_requests_test;
  import ttc_pkg::*;

  typedef struct packed {
    logic [1:0]  mode;
    logic [20:0] wx;
    logic [20:0] wy;
    logic [16:0] tx;
    logic [16:0] ty;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        rv;
    logic [16:0] rx;
    logic [16:0] ry;
    logic [5:0]  dsq;
    logic        hit;
    logic [5:0]  slot;
    logic        last;
  } answer_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [0:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] mode = 0;
  logic [20:0] world_x = 0, world_y = 0;
  logic [16:0] new_tile_x = 0, new_tile_y = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [1:0] result_kind;
  logic request_valid;
  logic [16:0] req_tile_x, req_tile_y;
  logic [5:0] distance_sq;
  logic hit;
  logic [5:0] slot_index;
  logic last;

  toroidal_tile_cache_with_miss_requests i_dut (.*);

  initial forever #2 clk = ~clk;

  // cache model
  tag_t        tags [SLOTS];
  logic [16:0] view_x, view_y;
  int          req_limit;

  cmd_t    pending_cmds[$];
  answer_t expected_answers[$];
  int      mismatches = 0;
  int      answers_seen = 0;
  int      requests_seen = 0;
  int      idle_cycles = 0;
  bit      timed_out = 0;
  bit      all_queued = 0;

  function automatic logic [16:0] world_to_tile(logic [20:0] w);
    logic signed [20:0] s;
    s = w;
    s = s >>> 4;
    return s[16:0];
  endfunction

  function automatic logic [5:0] slot_for(logic [16:0] x, logic [16:0] y);
    return {y[2:0], x[2:0]};
  endfunction

  function automatic bit in_window(logic [16:0] t, logic [16:0] v);
    logic signed [16:0] d;
    d = t - v;
    return d >= -HALF && d < HALF;
  endfunction

  function automatic void predict_answers(cmd_t c);
    answer_t a, found[$];
    logic [16:0] rx, ry;
    logic [5:0] s;
    int dx, dy;
    a = '0;
    case (c.mode)
      MODE_SET: begin
        view_x = world_to_tile(c.wx);
        view_y = world_to_tile(c.wy);
        for (int k = 0; k < WIN; k++)
          for (int j = 0; j < WIN; j++)
            for (int i = 0; i < WIN; i++) begin
              dx = i - HALF;
              dy = j - HALF;
              if ((dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy) == k) begin
                rx = view_x + 17'(dx);
                ry = view_y + 17'(dy);
                s = slot_for(rx, ry);
                if ((tags[s].x != rx || tags[s].y != ry) && found.size() < req_limit
                    && found.size() < SLOTS) begin
                  a = '0;
                  a.kind = KIND_REQUEST;
                  a.rv = 1;
                  a.rx = rx;
                  a.ry = ry;
                  a.dsq = 6'(dx * dx + dy * dy);
                  a.slot = s;
                  found.push_back(a);
                end
              end
            end
        if (found.size() == 0) begin
          a = '0;
          a.last = 1;
          expected_answers.push_back(a);
        end else begin
          // stable order by distance
          for (int d = 0; d <= 32; d++)
            foreach (found[m])
              if (found[m].dsq == d) expected_answers.push_back(found[m]);
          expected_answers[$].last = 1;
        end
      end
      MODE_INSTALL: begin
        s = slot_for(c.tx, c.ty);
        a.kind = KIND_INSTALL;
        a.hit = in_window(c.tx, view_x) && in_window(c.ty, view_y);
        a.slot = s;
        a.last = 1;
        if (a.hit) begin
          tags[s].x = c.tx;
          tags[s].y = c.ty;
        end
        expected_answers.push_back(a);
      end
      MODE_LOOKUP: begin
        rx = world_to_tile(c.wx);
        ry = world_to_tile(c.wy);
        s = slot_for(rx, ry);
        a.kind = KIND_LOOKUP;
        a.hit = tags[s].x == rx && tags[s].y == ry;
        a.slot = s;
        a.last = 1;
        expected_answers.push_back(a);
      end
      default: ;
    endcase
  endfunction

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_answers({mode, world_x, world_y, new_tile_x, new_tile_y});
        send_gap = gap_length();
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0 || pending_cmds.size() == 0) begin
          if (send_gap > 0) send_gap--;
          in_valid <= 0;
        end else begin
          cmd_t c;
          c = pending_cmds.pop_front();
          in_valid <= 1;
          mode <= c.mode;
          world_x <= c.wx;
          world_y <= c.wy;
          new_tile_x <= c.tx;
          new_tile_y <= c.ty;
        end
      end
    end
  end

  // monitor and receiver stalls
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        answer_t got, want;
        got = {result_kind, request_valid, req_tile_x, req_tile_y, distance_sq, hit,
               slot_index, last};
        answers_seen++;
        if (result_kind == KIND_REQUEST && request_valid) requests_seen++;
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transfer %h", got);
        end else begin
          want = expected_answers.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: kind %0d/%0d rv %0d/%0d x %h/%h y %h/%h d %0d/%0d",
                        " hit %0d/%0d slot %0d/%0d last %0d/%0d"},
                       want.kind, got.kind, want.rv, got.rv, want.rx, got.rx, want.ry,
                       got.ry, want.dsq, got.dsq, want.hit, got.hit, want.slot,
                       got.slot, want.last, got.last);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1;
      end else begin
        stall_left = gap_length();
        out_stall <= stall_left > 0;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 20000) timed_out = 1;
    end
  end

  task automatic write_limit(int value);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= 0;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    req_limit = value;
  endtask

  task automatic wait_drained();
    wait (pending_cmds.size() == 0 && !in_valid && expected_answers.size() == 0);
    repeat (80) @(posedge clk);
  endtask

  function automatic cmd_t make_cmd(logic [1:0] m, logic [20:0] wx, logic [20:0] wy,
                                    logic [16:0] tx, logic [16:0] ty);
    cmd_t c;
    c.mode = m; c.wx = wx; c.wy = wy; c.tx = tx; c.ty = ty;
    return c;
  endfunction

  // a position update followed by installs of tiles near it or at random, some followed by lookups
  task automatic queue_scene(logic [20:0] wx, logic [20:0] wy, int installs);
    logic [16:0] vx, vy;
    vx = world_to_tile(wx);
    vy = world_to_tile(wy);
    pending_cmds.push_back(make_cmd(MODE_SET, wx, wy, 17'($urandom), 17'($urandom)));
    for (int i = 0; i < installs; i++) begin
      logic [16:0] tx, ty;
      if ($urandom_range(0, 5) == 0) begin
        tx = 17'($urandom); ty = 17'($urandom);
      end else begin
        tx = vx + 17'($urandom_range(0, 9)) - 17'(5);
        ty = vy + 17'($urandom_range(0, 9)) - 17'(5);
      end
      pending_cmds.push_back(make_cmd(MODE_INSTALL, 21'($urandom), 21'($urandom),
                                      tx, ty));
      if ($urandom_range(0, 2) == 0)
        pending_cmds.push_back(make_cmd(MODE_LOOKUP,
          {tx, 4'($urandom)} + 21'($urandom_range(0, 1) ? 0 : 16),
          {ty, 4'($urandom)}, 17'($urandom), 17'($urandom)));
    end
  endtask

  initial begin
    int limits[5] = '{64, 0, 1, 127, 17};
    for (int s = 0; s < SLOTS; s++) begin
      tags[s].x = 17'(s % WIN + 1);
      tags[s].y = 0;
    end
    view_x = 0;
    view_y = 0;
    req_limit = 64;
    repeat (6) @(posedge clk);
    rst <= 0;
    repeat (70) @(posedge clk);

    // directed: extremes, every mode, wrap, rejected install, ignored mode
    pending_cmds.push_back(make_cmd(MODE_LOOKUP, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(MODE_SET, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(MODE_INSTALL, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(MODE_INSTALL, 0, 0, 17'h1fffc, 17'h1fffc));
    pending_cmds.push_back(make_cmd(MODE_INSTALL, 0, 0, 17'd4, 17'd0));
    pending_cmds.push_back(make_cmd(MODE_INSTALL, 0, 0, 17'h0ffff, 17'h10000));
    pending_cmds.push_back(make_cmd(MODE_LOOKUP, 21'h1ffff0, 21'h1ffff0, 0, 0));
    pending_cmds.push_back(make_cmd(MODE_LOOKUP, 21'h00000f, 21'h00000f, 0, 0));
    pending_cmds.push_back(make_cmd(MODE_NONE, 21'h1fffff, 21'h1fffff, 17'h1ffff,
                                    17'h1ffff));
    pending_cmds.push_back(make_cmd(MODE_SET, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(MODE_SET, 21'h0fffff, 21'h100000, 0, 0));
    pending_cmds.push_back(make_cmd(MODE_INSTALL, 0, 0, 17'h0ffff, 17'h10000));
    pending_cmds.push_back(make_cmd(MODE_INSTALL, 0, 0, 17'h10002, 17'h0fffd));
    pending_cmds.push_back(make_cmd(MODE_LOOKUP, 21'h0ffff0, 21'h100000, 0, 0));
    pending_cmds.push_back(make_cmd(MODE_SET, 21'h100000, 21'h0fffff, 0, 0));
    wait_drained();

    // each limit setting gets a few scenes
    foreach (limits[p]) begin
      write_limit(limits[p]);
      for (int n = 0; n < 4; n++) begin
        logic [20:0] wx, wy;
        wx = ($urandom_range(0, 3) == 0) ? 21'($urandom) : 21'($urandom_range(0, 300));
        wy = ($urandom_range(0, 3) == 0) ? 21'($urandom) : 21'($urandom_range(0, 300));
        queue_scene(wx, wy, $urandom_range(2, 6));
        if ($urandom_range(0, 4) == 0)
          pending_cmds.push_back(make_cmd(2'($urandom), 21'($urandom), 21'($urandom),
                                          17'($urandom), 17'($urandom)));
      end
      pending_cmds.push_back(make_cmd(MODE_SET, 21'($urandom_range(0, 300)), 0, 0, 0));
      wait_drained();
    end
    write_limit(64);
    all_queued = 1;
  end

  initial begin
    @(negedge rst);
    wait (all_queued || timed_out);
    if (!timed_out) repeat (200) @(posedge clk);
    if (timed_out) begin
      $display("watchdog expired with %0d answers outstanding", expected_answers.size());
      $display("Simulation FAILED");
    end else begin
      $display("covered %0d result transfers, %0d of them fetch requests,",
               answers_seen, requests_seen);
      $display("over directed corner items and random scenes at five request limits");
      if (mismatches == 0 && expected_answers.size() == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/ttc_pkg.sv
design/ttc_tag_ram.sv
design/ttc_req_ram.sv
design/toroidal_tile_cache_with_miss_requests.sv
sim/toroidal_tile_cache_with_miss_requests_test.sv
